### rtl/avf_pkg.sv
// shared types and constants for the axial voxel fetch block
package avf_pkg;

    typedef enum logic [1:0] {
        REQ_WR_MAP    = 2'd0,
        REQ_WR_WEIGHT = 2'd1,
        REQ_WR_PIXEL  = 2'd2,
        REQ_RD_VOXEL  = 2'd3
    } t_req;

    localparam logic [2:0] CFG_CUBE_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_CUBE_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_EXTRA_FRAMES = 3'd2;
    localparam logic [2:0] CFG_HALF_SWEEP   = 3'd3;
    localparam logic [2:0] CFG_ANTICLOCK    = 3'd4;
    localparam logic [2:0] CFG_PROBE_BOTTOM = 3'd5;
    localparam logic [2:0] CFG_HREFLECT     = 3'd6;

    localparam int ADDR_W = 21;
    localparam int WEIGHT_ONE = 65536;

    typedef struct packed {
        logic [7:0]  cube_width;
        logic [7:0]  cube_height;
        logic [7:0]  extra_frame_count;
        logic [20:0] half_sweep_size;
        logic        anticlockwise_scan;
        logic        probe_bottom;
        logic        horizontal_reflect;
    } t_cfg;

endpackage

### rtl/axial_voxel_fetch.sv
// top level: voxel fetch pipeline with map, weight and pixel stores
// an accepted input beat moves through the staged valid and payload registers, then the output register
// throughput: one beat per cycle; the pipeline advances whenever the output
// register is empty or being taken
// each store is written at the stage that reads it, so reads see every earlier write
// reset clears valid bits and returns configuration to its defaults; the stores are not cleared
module axial_voxel_fetch
    import avf_pkg::*;
#(
    parameter int MAX_DIM      = 128,
    parameter int MAP_DEPTH    = 16384,
    parameter int WEIGHT_DEPTH = 128,
    parameter int PIXEL_DEPTH  = 2097152
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [20:0] i_write_addr,
    input  logic [20:0] i_write_data,
    input  logic signed [8:0] i_pos_x,
    input  logic signed [8:0] i_pos_y,
    input  logic signed [8:0] i_pos_z,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [20:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_voxel_value,
    output logic        o_is_read_result
);
    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int MAW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int WAW = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
    localparam int PAW = (PIXEL_DEPTH > 1) ? $clog2(PIXEL_DEPTH) : 1;
    localparam int FSW = 2 * DW;
    localparam int VW  = 3 * DW;
    localparam int IW  = 32;
    localparam int NS  = 9;

    t_cfg cfg;
    avf_regs u_regs (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_index, .i_cfg_data, .o_cfg(cfg)
    );

    // stall control: whole pipeline moves together
    logic adv;
    logic [NS-1:0] r_v;
    assign adv = !o_valid || i_ready;
    assign o_ready = adv;

    // shared payload through the stages
    t_req        r_kind [NS];
    logic [20:0] r_wa   [NS];
    logic [20:0] r_wd   [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_kind[0] <= t_req'(i_req_type);
            r_wa[0]   <= i_write_addr;
            r_wd[0]   <= i_write_data;
            for (int s = 1; s < NS; s++) begin
                r_kind[s] <= r_kind[s-1];
                r_wa[s]   <= r_wa[s-1];
                r_wd[s]   <= r_wd[s-1];
            end
        end
    end

    // stage 0: saturate dims, clamp and flip coordinates
    logic [DW-1:0] w0, h0;
    logic [DW-1:0] cx, cy, cz;
    function automatic logic [DW-1:0] sat_dim(input logic [7:0] v);
        if (v == 8'd0) return DW'(1);
        if (32'(v) > 32'(MAX_DIM)) return DW'(MAX_DIM);
        return DW'(v);
    endfunction
    function automatic logic [DW-1:0] clampc(input logic signed [8:0] p,
                                             input logic [DW-1:0] sz);
        logic [DW:0] m;
        m = {1'b0, sz} - 1'b1;
        if (p < 0) return '0;
        if ({1'b0, 10'(unsigned'(p))} > 11'(m)) return DW'(m);
        return DW'(unsigned'(p));
    endfunction
    always_comb begin
        w0 = sat_dim(cfg.cube_width);
        h0 = sat_dim(cfg.cube_height);
        cx = clampc(i_pos_x, w0);
        cy = clampc(i_pos_y, w0);
        cz = clampc(i_pos_z, h0);
        if (cfg.anticlockwise_scan) cy = w0 - 1'b1 - cy;
        if (cfg.probe_bottom) cz = h0 - 1'b1 - cz;
        if (cfg.horizontal_reflect) cx = w0 - 1'b1 - cx;
    end

    logic [DW-1:0] r_x1, r_y1, r_z1, r_w1, r_h1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x1 <= cx; r_y1 <= cy; r_z1 <= cz; r_w1 <= w0; r_h1 <= h0;
        end
    end

    // stage 1: map index and z*w, frame size
    logic [FSW-1:0] r_midx2, r_zw2, r_fs2;
    logic [DW-1:0]  r_w2;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_midx2 <= FSW'(r_y1) + FSW'(r_x1) * FSW'(r_w1);
            r_zw2   <= FSW'(r_z1) * FSW'(r_w1);
            r_fs2   <= FSW'(r_w1) * FSW'(r_h1);
            r_w2    <= r_w1;
        end
    end

    // stage 2: map write and read (registered), volume
    logic [20:0] map_mem [MAP_DEPTH];
    logic [20:0] r_ent3;
    logic        r_mok3;
    logic [FSW-1:0] r_zw3, r_fs3;
    logic [VW-1:0]  r_vol3;
    logic [DW-1:0]  r_w3;
    always_ff @(posedge i_clk) begin
        if (r_v[1] && adv && r_kind[1] == REQ_WR_MAP &&
            32'(r_wa[1]) < 32'(MAP_DEPTH))
            map_mem[MAW'(r_wa[1])] <= r_wd[1];
        if (adv) begin
            r_ent3 <= map_mem[MAW'(r_midx2)];
            r_mok3 <= 32'(r_midx2) < 32'(MAP_DEPTH);
            r_zw3  <= r_zw2;
            r_fs3  <= r_fs2;
            r_vol3 <= VW'(r_fs2) * VW'(r_w2);
            r_w3   <= r_w2;
        end
    end

    // stage 3: index = entry + z*w, then restoring division by frame size
    // and by width, six quotient bits per stage over four stages
    logic [IW-1:0]  idx3;
    logic           zero3;
    assign idx3  = IW'(r_ent3) + IW'(r_zw3);
    assign zero3 = !r_mok3 || r_ent3 == '0;

    localparam int QW = 24;
    localparam int QS = 4;
    localparam int SPS = QW / QS;
    logic [IW-1:0]  r_rem  [QS+1];
    logic [IW-1:0]  r_remw [QS+1];
    logic [QW-1:0]  r_q    [QS+1];
    logic [FSW-1:0] r_fsd  [QS+1];
    logic [IW-1:0]  r_idxd [QS+1];
    logic [VW-1:0]  r_vold [QS+1];
    logic [DW-1:0]  r_wd_  [QS+1];
    logic           r_zd   [QS+1];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rem[0]  <= idx3;
            r_remw[0] <= idx3;
            r_q[0]    <= '0;
            r_fsd[0]  <= r_fs3;
            r_idxd[0] <= idx3;
            r_vold[0] <= r_vol3;
            r_wd_[0]  <= r_w3;
            r_zd[0]   <= zero3;
        end
    end
    for (genvar g = 0; g < QS; g++) begin : g_div
        logic [IW-1:0] rem_c;
        logic [IW-1:0] remw_c;
        logic [QW-1:0] q_c;
        always_comb begin
            rem_c  = r_rem[g];
            remw_c = r_remw[g];
            q_c    = r_q[g];
            for (int b = 0; b < SPS; b++) begin
                if ((64'(rem_c) >> (QW - 1 - g * SPS - b)) >= 64'(r_fsd[g])) begin
                    rem_c = rem_c - IW'(64'(r_fsd[g]) << (QW - 1 - g * SPS - b));
                    q_c[QW - 1 - g * SPS - b] = 1'b1;
                end
                if ((64'(remw_c) >> (QW - 1 - g * SPS - b)) >= 64'(r_wd_[g])) begin
                    remw_c = remw_c - IW'(64'(r_wd_[g]) << (QW - 1 - g * SPS - b));
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_rem[g+1]  <= rem_c;
                r_remw[g+1] <= remw_c;
                r_q[g+1]    <= q_c;
                r_fsd[g+1]  <= r_fsd[g];
                r_idxd[g+1] <= r_idxd[g];
                r_vold[g+1] <= r_vold[g];
                r_wd_[g+1]  <= r_wd_[g];
                r_zd[g+1]   <= r_zd[g];
            end
        end
    end

    // final stage: mirror, pixel and weight reads, blend
    // the mirrored pixel sits at index + w - 1 - 2*(index mod w) past the sweep offset
    logic [QW-1:0]  fr;
    logic [DW-1:0]  ww;
    logic [DW-1:0]  col;
    logic [IW+8:0]  idx2;
    logic [IW-1:0]  idx1;
    logic           blend, ok1, ok2;
    assign fr   = r_q[QS];
    assign ww   = r_wd_[QS];
    assign col  = DW'(r_remw[QS]);
    assign idx1 = r_idxd[QS];
    assign blend = 32'(fr) < 32'(cfg.extra_frame_count);
    assign idx2 = (IW+9)'(cfg.half_sweep_size) + (IW+9)'(idx1) + (IW+9)'(ww)
                - (IW+9)'(1) - ((IW+9)'(col) << 1);
    assign ok1 = 64'(idx1) < 64'(r_vold[QS]) && 64'(idx1) < 64'(PIXEL_DEPTH);
    assign ok2 = 64'(idx2) < 64'(r_vold[QS]) && 64'(idx2) < 64'(PIXEL_DEPTH)
               && 32'(fr) < 32'(WEIGHT_DEPTH);

    logic [7:0]  pix_mem [PIXEL_DEPTH];
    logic [16:0] wt_mem  [WEIGHT_DEPTH];
    logic [7:0]  r_p1, r_p2;
    logic [16:0] r_wt;
    logic        r_bl, r_z, r_ok1, r_ok2;
    always_ff @(posedge i_clk) begin
        if (r_v[NS-2] && adv && r_kind[NS-2] == REQ_WR_PIXEL &&
            32'(r_wa[NS-2]) < 32'(PIXEL_DEPTH))
            pix_mem[PAW'(r_wa[NS-2])] <= r_wd[NS-2][7:0];
        if (r_v[NS-2] && adv && r_kind[NS-2] == REQ_WR_WEIGHT &&
            32'(r_wa[NS-2]) < 32'(WEIGHT_DEPTH))
            wt_mem[WAW'(r_wa[NS-2])] <= r_wd[NS-2][16:0];
        if (adv) begin
            r_p1  <= pix_mem[idx1[PAW-1:0]];
            r_p2  <= pix_mem[idx2[PAW-1:0]];
            r_wt  <= wt_mem[fr[WAW-1:0]];
            r_bl  <= blend;
            r_z   <= r_zd[QS];
            r_ok1 <= ok1;
            r_ok2 <= ok2 && ok1;
        end
    end

    logic [16:0] wsat;
    logic [25:0] mix;
    logic [7:0]  val;
    assign wsat = (r_wt > 17'(WEIGHT_ONE)) ? 17'(WEIGHT_ONE) : r_wt;
    assign mix = 26'(r_p1) * 26'(wsat) + 26'(r_p2) * (26'(WEIGHT_ONE) - 26'(wsat));
    always_comb begin
        if (r_z) val = '0;
        else if (r_bl) val = r_ok2 ? mix[23:16] : 8'd0;
        else val = r_ok1 ? r_p1 : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= r_v[NS-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_is_read_result <= r_kind[NS-1] == REQ_RD_VOXEL;
            o_voxel_value    <= (r_kind[NS-1] == REQ_RD_VOXEL) ? val : 8'd0;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_voxel_value))
        else $error("output beat changed while stalled");
    a_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_v))
        else $error("pipeline moved during stall");
    a_wr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_read_result |-> o_voxel_value == 8'd0)
        else $error("write beat returned data");
endmodule

### rtl/avf_regs.sv
// configuration register bank
module avf_regs
    import avf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [20:0] i_cfg_data,
    output t_cfg        o_cfg
);
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cube_width         <= 8'd128;
            r_cfg.cube_height        <= 8'd128;
            r_cfg.extra_frame_count  <= 8'd0;
            r_cfg.half_sweep_size    <= '0;
            r_cfg.anticlockwise_scan <= 1'b0;
            r_cfg.probe_bottom       <= 1'b0;
            r_cfg.horizontal_reflect <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CUBE_WIDTH:   r_cfg.cube_width <= i_cfg_data[7:0];
                CFG_CUBE_HEIGHT:  r_cfg.cube_height <= i_cfg_data[7:0];
                CFG_EXTRA_FRAMES: r_cfg.extra_frame_count <= i_cfg_data[7:0];
                CFG_HALF_SWEEP:   r_cfg.half_sweep_size <= i_cfg_data;
                CFG_ANTICLOCK:    r_cfg.anticlockwise_scan <= i_cfg_data[0];
                CFG_PROBE_BOTTOM: r_cfg.probe_bottom <= i_cfg_data[0];
                CFG_HREFLECT:     r_cfg.horizontal_reflect <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end
endmodule
